>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL of the beep/burst tone sequencer.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BBTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define BBTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/bbts_pkg.sv
// Types and constants for the beep/burst tone sequencer.
// No dependencies; used by bbts_next and the top level.
package bbts_pkg;

	localparam int FREQ_W  = 16;
	localparam int COUNT_W = 8;
	localparam int CMD_W   = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK  = 2'd0,
		CMD_TONE  = 2'd1,
		CMD_BURST = 2'd2,
		CMD_STOP  = 2'd3
	} cmd_t;

	// Sequencer state that does not depend on the time width
	typedef struct packed {
		logic [FREQ_W-1:0]  drive_freq;
		logic               playing;
		logic               stop_armed;
		logic [COUNT_W-1:0] burst_remaining;
		logic               phase_on;
		logic [FREQ_W-1:0]  burst_freq;
	} tone_state_t;

endpackage

>>> rtl/bbts_next.sv
// Next-state logic of the tone sequencer for one command.
// Depends on bbts_pkg.
module bbts_next #(
	parameter int TIME_WIDTH = 16
) (
	input  bbts_pkg::tone_state_t         cur,
	input  logic [TIME_WIDTH-1:0]         stop_cd,
	input  logic [TIME_WIDTH-1:0]         phase_cd,
	input  logic [TIME_WIDTH-1:0]         on_len,
	input  logic [TIME_WIDTH-1:0]         off_len,
	input  logic                          sound_enable,
	input  logic [bbts_pkg::CMD_W-1:0]    command,
	input  logic [bbts_pkg::FREQ_W-1:0]   frequency,
	input  logic [15:0]                   duration,
	input  logic [bbts_pkg::COUNT_W-1:0]  beep_count,
	input  logic [15:0]                   on_time,
	input  logic [15:0]                   off_time,
	output bbts_pkg::tone_state_t         nxt,
	output logic [TIME_WIDTH-1:0]         nxt_stop_cd,
	output logic [TIME_WIDTH-1:0]         nxt_phase_cd,
	output logic [TIME_WIDTH-1:0]         nxt_on_len,
	output logic [TIME_WIDTH-1:0]         nxt_off_len
);

	localparam int CLAMP_W = (TIME_WIDTH > 16) ? TIME_WIDTH : 16;
	localparam logic [TIME_WIDTH-1:0] T_ONE = TIME_WIDTH'(1);
	localparam logic [TIME_WIDTH-1:0] T_MAX = {TIME_WIDTH{1'b1}};
	localparam logic [bbts_pkg::COUNT_W-1:0] C_ONE = {{(bbts_pkg::COUNT_W-1){1'b0}}, 1'b1};

	// saturate a 16-bit millisecond length into the countdown width
	function automatic logic [TIME_WIDTH-1:0] clamp_time(input logic [15:0] v);
		logic [CLAMP_W-1:0] wide;
		wide = CLAMP_W'(v);
		if (wide > CLAMP_W'(T_MAX)) begin
			return T_MAX;
		end
		return TIME_WIDTH'(wide);
	endfunction

	logic                  expired;
	logic [TIME_WIDTH-1:0] on_clamped;
	bbts_pkg::cmd_t        cmd;

	assign cmd        = bbts_pkg::cmd_t'(command);
	assign on_clamped = clamp_time(on_time);

	always_comb begin
		nxt          = cur;
		nxt_stop_cd  = stop_cd;
		nxt_phase_cd = phase_cd;
		nxt_on_len   = on_len;
		nxt_off_len  = off_len;
		expired      = 1'b0;
		unique case (cmd)
			bbts_pkg::CMD_TICK: begin
				if (cur.playing && cur.stop_armed) begin
					if (stop_cd <= T_ONE) begin
						expired             = 1'b1;
						nxt.drive_freq      = '0;
						nxt.playing         = 1'b0;
						nxt.stop_armed      = 1'b0;
						nxt_stop_cd         = '0;
						nxt.burst_remaining = '0;
					end else begin
						nxt_stop_cd = stop_cd - T_ONE;
					end
				end
				// an expiring timed tone suppresses the burst step
				if (!expired && cur.burst_remaining != '0) begin
					if (phase_cd <= T_ONE) begin
						if (cur.phase_on) begin
							nxt.drive_freq      = '0;
							nxt.phase_on        = 1'b0;
							nxt_phase_cd        = off_len;
							nxt.burst_remaining = cur.burst_remaining - C_ONE;
							if (cur.burst_remaining == C_ONE) begin
								nxt.playing = 1'b0;
							end
						end else begin
							nxt.drive_freq = cur.burst_freq;
							nxt.phase_on   = 1'b1;
							nxt_phase_cd   = on_len;
						end
					end else begin
						nxt_phase_cd = phase_cd - T_ONE;
					end
				end
			end
			bbts_pkg::CMD_TONE: begin
				if (sound_enable) begin
					if (frequency == '0) begin
						nxt.drive_freq      = '0;
						nxt.playing         = 1'b0;
						nxt.stop_armed      = 1'b0;
						nxt_stop_cd         = '0;
						nxt.burst_remaining = '0;
					end else begin
						nxt.drive_freq = frequency;
						nxt.playing    = 1'b1;
						nxt.stop_armed = (duration != '0);
						nxt_stop_cd    = (duration != '0) ? clamp_time(duration) : '0;
					end
				end
			end
			bbts_pkg::CMD_BURST: begin
				if (sound_enable && beep_count != '0) begin
					// burst parameters latch even when the frequency stops it
					nxt.burst_freq = frequency;
					nxt_on_len     = on_clamped;
					nxt_off_len    = clamp_time(off_time);
					nxt.phase_on   = 1'b1;
					nxt_phase_cd   = on_clamped;
					nxt.stop_armed = 1'b0;
					nxt_stop_cd    = '0;
					if (frequency == '0) begin
						nxt.drive_freq      = '0;
						nxt.playing         = 1'b0;
						nxt.burst_remaining = '0;
					end else begin
						nxt.drive_freq      = frequency;
						nxt.playing         = 1'b1;
						nxt.burst_remaining = beep_count;
					end
				end
			end
			bbts_pkg::CMD_STOP: begin
				nxt.drive_freq      = '0;
				nxt.playing         = 1'b0;
				nxt.stop_armed      = 1'b0;
				nxt_stop_cd         = '0;
				nxt.burst_remaining = '0;
			end
		endcase
	end

endmodule

>>> rtl/beep_burst_tone_sequencer.sv
// Top level of the beep/burst tone sequencer: handshakes, state and result registers.
// Depends on bbts_pkg, bbts_next and assert_macros.svh.
`include "assert_macros.svh"

// Beep/burst tone sequencer. Each input transfer is one command: a one-millisecond
// tick, a tone (frequency plus duration, duration 0 = continuous, frequency 0 =
// stop), a burst (count, frequency, on and off times) or a stop. Every command
// yields exactly one result transfer with the frequency driven to the buzzer
// (0 = silent), a busy flag and the number of burst beeps still to complete.
// Throughput is one command per clock while out_stall is low; a command's result
// is registered after its transfer (the input register captures it, then the
// state update is committed into the result register when stage 1 advances).
// The state update for each command is a single combinational step, so
// commands may follow back to back. in_stall rises only while a result waits
// in the output register and the input register also holds a command.
// sound_enable resets to 1; writing 0 silences and clears any tone or burst.
// Configuration writes are meant for idle periods only.
module beep_burst_tone_sequencer #(
	parameter int TIME_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bbts_pkg::CMD_W-1:0]    command,
	input  logic [bbts_pkg::FREQ_W-1:0]   frequency,
	input  logic [15:0]                   duration,
	input  logic [bbts_pkg::COUNT_W-1:0]  beep_count,
	input  logic [15:0]                   on_time,
	input  logic [15:0]                   off_time,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bbts_pkg::FREQ_W-1:0]   tone_out,
	output logic                          busy_res,
	output logic [bbts_pkg::COUNT_W-1:0]  beeps_left
);

	// stage 1: registered command
	logic                          valid_s1;
	logic [bbts_pkg::CMD_W-1:0]    command_s1;
	logic [bbts_pkg::FREQ_W-1:0]   frequency_s1;
	logic [15:0]                   duration_s1;
	logic [bbts_pkg::COUNT_W-1:0]  beep_count_s1;
	logic [15:0]                   on_time_s1;
	logic [15:0]                   off_time_s1;

	// sequencer state
	logic                  sound_enable_q;
	bbts_pkg::tone_state_t state_q;
	logic [TIME_WIDTH-1:0] stop_cd_q;
	logic [TIME_WIDTH-1:0] phase_cd_q;
	logic [TIME_WIDTH-1:0] on_len_q;
	logic [TIME_WIDTH-1:0] off_len_q;

	// next state for the command in stage 1
	bbts_pkg::tone_state_t state_nxt;
	logic [TIME_WIDTH-1:0] stop_cd_nxt;
	logic [TIME_WIDTH-1:0] phase_cd_nxt;
	logic [TIME_WIDTH-1:0] on_len_nxt;
	logic [TIME_WIDTH-1:0] off_len_nxt;

	// result register
	logic                          out_valid_q;
	logic [bbts_pkg::FREQ_W-1:0]   tone_out_q;
	logic                          busy_q;
	logic [bbts_pkg::COUNT_W-1:0]  beeps_left_q;

	logic advance;       // stage 1 command commits and its result is registered
	logic in_take;       // input transfer
	logic disable_wr;    // configuration write that turns sound off
	logic state_silent;  // no tone, no burst

	// stage 1 moves on whenever the result register is free or draining
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	assign disable_wr   = cfg_wr_en && !cfg_wr_data;
	assign state_silent = (state_q.drive_freq == '0) && !state_q.playing &&
		(state_q.burst_remaining == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			command_s1    <= command;
			frequency_s1  <= frequency;
			duration_s1   <= duration;
			beep_count_s1 <= beep_count;
			on_time_s1    <= on_time;
			off_time_s1   <= off_time;
		end
	end

	bbts_next #(
		.TIME_WIDTH (TIME_WIDTH)
	) u_next (
		.cur          (state_q),
		.stop_cd      (stop_cd_q),
		.phase_cd     (phase_cd_q),
		.on_len       (on_len_q),
		.off_len      (off_len_q),
		.sound_enable (sound_enable_q),
		.command      (command_s1),
		.frequency    (frequency_s1),
		.duration     (duration_s1),
		.beep_count   (beep_count_s1),
		.on_time      (on_time_s1),
		.off_time     (off_time_s1),
		.nxt          (state_nxt),
		.nxt_stop_cd  (stop_cd_nxt),
		.nxt_phase_cd (phase_cd_nxt),
		.nxt_on_len   (on_len_nxt),
		.nxt_off_len  (off_len_nxt)
	);

	// State update. A disabling configuration write clears the tone and burst
	// as a stop does.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sound_enable_q <= 1'b1;
			state_q        <= '0;
			stop_cd_q      <= '0;
			phase_cd_q     <= '0;
			on_len_q       <= '0;
			off_len_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				sound_enable_q <= cfg_wr_data;
			end
			if (disable_wr) begin
				state_q.drive_freq      <= '0;
				state_q.playing         <= 1'b0;
				state_q.stop_armed      <= 1'b0;
				state_q.burst_remaining <= '0;
				stop_cd_q               <= '0;
			end else if (advance) begin
				state_q    <= state_nxt;
				stop_cd_q  <= stop_cd_nxt;
				phase_cd_q <= phase_cd_nxt;
				on_len_q   <= on_len_nxt;
				off_len_q  <= off_len_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tone_out_q   <= state_nxt.drive_freq;
			busy_q       <= state_nxt.playing || (state_nxt.burst_remaining != '0);
			beeps_left_q <= state_nxt.burst_remaining;
		end
	end

	assign out_valid  = out_valid_q;
	assign tone_out   = tone_out_q;
	assign busy_res   = busy_q;
	assign beeps_left = beeps_left_q;

	// Checks
	`BBTS_ASSERT(a_beeps_imply_busy, clk, arst_n, !out_valid || beeps_left == '0 || busy_res, "beeps but not busy")
	`BBTS_ASSERT_NEXT(a_disable_silences, clk, arst_n, disable_wr, state_silent, "disable did not silence")
	`BBTS_ASSERT(a_stall_needs_cmd, clk, arst_n, !in_stall || (valid_s1 && out_valid_q), "stall while free")

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Testbench for beep_burst_tone_sequencer: directed and random command transfers,
// checked against an in-bench model of the tone and burst state. Depends on bbts_pkg.
module tb;

	localparam int FREQ_W       = bbts_pkg::FREQ_W;
	localparam int COUNT_W      = bbts_pkg::COUNT_W;
	localparam int CMD_W        = bbts_pkg::CMD_W;
	localparam int CYCLE_LIMIT  = 400_000;
	localparam int DRAIN_CYCLES = 4;  // idle clocks added after the last result comes back
	localparam int MAX_PRINTS   = 40;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 200;

	// One expected result transfer
	typedef struct packed {
		logic [FREQ_W-1:0]  freq;
		logic               busy;
		logic [COUNT_W-1:0] left;
	} tone_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic                cfg_wr_data = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [CMD_W-1:0]    command = bbts_pkg::CMD_TICK;
	logic [FREQ_W-1:0]   frequency = '0;
	logic [15:0]         duration = '0;
	logic [COUNT_W-1:0]  beep_count = '0;
	logic [15:0]         on_time = '0;
	logic [15:0]         off_time = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [FREQ_W-1:0]   tone_out;
	logic                busy_res;
	logic [COUNT_W-1:0]  beeps_left;

	beep_burst_tone_sequencer #(.TIME_WIDTH(16)) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.frequency   (frequency),
		.duration    (duration),
		.beep_count  (beep_count),
		.on_time     (on_time),
		.off_time    (off_time),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tone_out    (tone_out),
		.busy_res    (busy_res),
		.beeps_left  (beeps_left)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Sequencer model: mirrors the block's state, one update per command.
	// ------------------------------------------------------------------
	logic               enabled;
	logic [FREQ_W-1:0]  cur_freq;
	logic               tone_on;      // a tone or a burst is sounding
	logic               timed_stop;   // tone has a deadline
	logic [15:0]        stop_left;    // ms until the deadline
	logic [COUNT_W-1:0] beeps_rem;
	logic               in_on_phase;
	logic [15:0]        phase_left;
	logic [FREQ_W-1:0]  burst_hz;
	logic [15:0]        on_ms;
	logic [15:0]        off_ms;

	tone_result_t expected_tones[$];  // oldest first
	int           errors = 0;
	int           cycle_count = 0;
	int           stall_left = 0;
	bit           no_gaps = 1'b0;     // sender may idle between transfers unless set
	bit           no_stalls = 1'b0;   // receiver may stall unless set

	function automatic void clear_model();
		enabled     = 1'b1;
		cur_freq    = '0;
		tone_on     = 1'b0;
		timed_stop  = 1'b0;
		stop_left   = '0;
		beeps_rem   = '0;
		in_on_phase = 1'b0;
		phase_left  = '0;
		burst_hz    = '0;
		on_ms       = '0;
		off_ms      = '0;
	endfunction

	// STOP: silence and drop any tone deadline and burst
	function automatic void silence();
		cur_freq   = '0;
		tone_on    = 1'b0;
		timed_stop = 1'b0;
		stop_left  = '0;
		beeps_rem  = '0;
	endfunction

	function automatic void start_tone(logic [FREQ_W-1:0] f, logic [15:0] d);
		if (f == '0) begin
			silence();
		end else begin
			cur_freq   = f;
			tone_on    = 1'b1;
			timed_stop = (d != '0);
			stop_left  = d;
		end
	endfunction

	// One millisecond tick: tone deadline first; an expiring tone ends
	// everything and skips the burst step on this tick.
	function automatic void advance_ms();
		logic expired;
		expired = 1'b0;
		if (tone_on && timed_stop) begin
			if (stop_left <= 16'd1) begin
				silence();
				expired = 1'b1;
			end else begin
				stop_left = stop_left - 16'd1;
			end
		end
		if (!expired && beeps_rem != '0) begin
			if (phase_left <= 16'd1) begin
				if (in_on_phase) begin
					cur_freq    = '0;
					in_on_phase = 1'b0;
					phase_left  = off_ms;
					beeps_rem   = beeps_rem - COUNT_W'(1);
					if (beeps_rem == '0)
						tone_on = 1'b0;
				end else begin
					cur_freq    = burst_hz;
					in_on_phase = 1'b1;
					phase_left  = on_ms;
				end
			end else begin
				phase_left = phase_left - 16'd1;
			end
		end
	endfunction

	function automatic tone_result_t predict_tone(bbts_pkg::cmd_t cmd, logic [FREQ_W-1:0] f,
			logic [15:0] d, logic [COUNT_W-1:0] cnt, logic [15:0] ont, logic [15:0] offt);
		case (cmd)
			bbts_pkg::CMD_TICK: advance_ms();
			bbts_pkg::CMD_TONE: begin
				if (enabled)
					start_tone(f, d);
			end
			bbts_pkg::CMD_BURST: begin
				// count zero or disabled: ignored entirely
				if (enabled && cnt != '0) begin
					beeps_rem   = cnt;
					burst_hz    = f;
					on_ms       = ont;
					off_ms      = offt;
					in_on_phase = 1'b1;
					phase_left  = ont;
					start_tone(f, 16'd0);  // continuous, cancels a deadline
				end
			end
			default: silence();
		endcase
		return '{freq: cur_freq, busy: tone_on || beeps_rem != '0, left: beeps_rem};
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic report_mismatch(string what, int got, int want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want,
				cycle_count);
	endtask

	// Result side: compare each transfer, then draw the stall before the next one
	always @(posedge clk) begin : check_results
		tone_result_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_tones.size() == 0) begin
					report_mismatch("unexpected result transfer", tone_out, 0);
				end else begin
					want = expected_tones.pop_front();
					if (tone_out !== want.freq)
						report_mismatch("tone_out", tone_out, want.freq);
					if (busy_res !== want.busy)
						report_mismatch("busy_res", busy_res, want.busy);
					if (beeps_left !== want.left)
						report_mismatch("beeps_left", beeps_left, want.left);
				end
				stall_left = no_stalls ? 0 : $urandom_range(0, 9);
			end else if (stall_left != 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Command side
	// ------------------------------------------------------------------
	// Sends one command transfer; valid stays high into the next call
	// when no gap is drawn, so back-to-back transfers happen.
	task automatic send_command(bbts_pkg::cmd_t cmd, logic [FREQ_W-1:0] f, logic [15:0] d,
			logic [COUNT_W-1:0] cnt, logic [15:0] ont, logic [15:0] offt);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		command    <= cmd;
		frequency  <= f;
		duration   <= d;
		beep_count <= cnt;
		on_time    <= ont;
		off_time   <= offt;
		do @(posedge clk); while (in_stall);
		expected_tones.push_back(predict_tone(cmd, f, d, cnt, ont, offt));
	endtask

	// Idle the command side until every result is back
	task automatic wait_quiet();
		in_valid <= 1'b0;
		while (expected_tones.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// sound_enable write, only while the block is idle
	task automatic write_enable(logic value);
		wait_quiet();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		enabled = value;
		if (!value)
			silence();  // disabling also stops
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_tones();
		write_enable(1'b1);
		// continuous
		send_command(bbts_pkg::CMD_TONE, 16'hFFFF, 16'd0, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_command(bbts_pkg::CMD_TICK, 16'h0000, 16'h0000, 8'h00, 16'h0000, 16'h0000);
		send_command(bbts_pkg::CMD_TONE, 16'd1, 16'd1, 8'h00, 16'h0, 16'h0);
		// expires
		send_command(bbts_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_command(bbts_pkg::CMD_TONE, 16'h1234, 16'hFFFF, 8'h00, 16'h0, 16'h0);
		send_command(bbts_pkg::CMD_TONE, 16'd0, 16'd5, 8'h00, 16'h0, 16'h0); // freq 0 = stop
		send_command(bbts_pkg::CMD_TONE, 16'h00AA, 16'd2, 8'h00, 16'h0, 16'h0);
		send_command(bbts_pkg::CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0, 16'h0);
		send_command(bbts_pkg::CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0, 16'h0);
	endtask

	task automatic test_bursts();
		send_command(bbts_pkg::CMD_BURST, 16'd500, 16'd0, 8'd0, 16'd3, 16'd3); // count 0
		send_command(bbts_pkg::CMD_BURST, 16'd0, 16'd0, 8'd3, 16'd3, 16'd3);   // freq 0 = stop
		// zero phase lengths: every tick flips the phase
		send_command(bbts_pkg::CMD_BURST, 16'hFFFF, 16'd0, 8'd2, 16'd0, 16'd0);
		repeat (4) send_command(bbts_pkg::CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0, 16'h0);
		// tone over a running burst, then its deadline ends the burst
		send_command(bbts_pkg::CMD_BURST, 16'd777, 16'd0, 8'hFF, 16'd1, 16'hFFFF);
		send_command(bbts_pkg::CMD_TONE, 16'h4321, 16'd3, 8'h0, 16'h0, 16'h0);
		repeat (3) send_command(bbts_pkg::CMD_TICK, 16'h0, 16'h0, 8'h0, 16'h0, 16'h0);
	endtask

	task automatic test_stop_and_disable();
		send_command(bbts_pkg::CMD_BURST, 16'd1000, 16'd0, 8'd5, 16'd3, 16'd3);
		send_command(bbts_pkg::CMD_STOP, 16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
		send_command(bbts_pkg::CMD_TONE, 16'd2000, 16'd0, 8'd0, 16'd0, 16'd0);
		write_enable(1'b0);  // silences the running tone
		send_command(bbts_pkg::CMD_TONE, 16'd100, 16'd0, 8'd0, 16'd0, 16'd0);
		send_command(bbts_pkg::CMD_BURST, 16'd100, 16'd0, 8'd4, 16'd2, 16'd2);
		send_command(bbts_pkg::CMD_TICK, 16'd0, 16'd0, 8'd0, 16'd0, 16'd0);
		write_enable(1'b1);
	endtask

	// Phase lengths and durations: mostly short so deadlines and phase
	// changes happen often, sometimes zero, sometimes anything.
	function automatic logic [15:0] pick_ms();
		case ($urandom_range(0, 9))
			0:       return 16'd0;
			1:       return 16'($urandom_range(0, 16'hFFFF));
			default: return 16'($urandom_range(1, 12));
		endcase
	endfunction

	function automatic logic [FREQ_W-1:0] pick_freq();
		case ($urandom_range(0, 9))
			0:       return '0;
			1, 2, 3: return FREQ_W'($urandom_range(0, 16'hFFFF));
			default: return FREQ_W'($urandom_range(1, 4000));
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_count();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return COUNT_W'($urandom_range(0, 255));
			default: return COUNT_W'($urandom_range(1, 5));
		endcase
	endfunction

	task automatic test_random_traffic();
		int sel;
		for (int p = 0; p < PHASES; p++) begin
			// first phase enabled, one phase disabled, the rest random
			write_enable(p == 0 ? 1'b1 : (p == 3 ? 1'b0 : logic'($urandom_range(0, 4) != 0)));
			no_gaps   = ($urandom_range(0, 3) == 0);
			no_stalls = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < 55)
					send_command(bbts_pkg::CMD_TICK, 16'($urandom), 16'($urandom),
						8'($urandom), 16'($urandom), 16'($urandom));
				else if (sel < 72)
					send_command(bbts_pkg::CMD_TONE, pick_freq(), pick_ms(), 8'($urandom),
						16'($urandom), 16'($urandom));
				else if (sel < 92)
					send_command(bbts_pkg::CMD_BURST, pick_freq(), 16'($urandom),
						pick_count(), pick_ms(), pick_ms());
				else
					send_command(bbts_pkg::CMD_STOP, 16'($urandom), 16'($urandom),
						8'($urandom), 16'($urandom), 16'($urandom));
			end
		end
		no_gaps   = 1'b0;
		no_stalls = 1'b0;
	endtask

	initial begin
		clear_model();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tones();
		test_bursts();
		test_stop_and_disable();
		test_random_traffic();

		wait_quiet();
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
